// ===== rtl/dfst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfst_pkg: shared types and constants of the duplicate-free set table
// Capacity, element width, operation codes, sequencer states and the
// structs that pass between the sequencer, the entry memory and the top.
// ----------------------------------------------------------------------------
package dfst_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned ELEM_BITS = 32;
  localparam int unsigned IDX_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

  // fixed field widths of the channels
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef logic [ELEM_BITS-1:0] elem_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    elem_t wdata;
    idx_t  raddr;
  } mem_req_t;

  typedef struct packed {
    logic               success;
    logic               full_reject;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } result_t;

  // element as stored: low ELEM_BITS of the sign-extended field
  function automatic elem_t to_elem(logic signed [VALUE_W-1:0] v);
    logic signed [ELEM_BITS+VALUE_W-1:0] ext;
    ext = (ELEM_BITS+VALUE_W)'(v);
    return ext[ELEM_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dfst_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfst_in_if: operation channel
// Valid/ready channel that carries one operation code and one value.
// ----------------------------------------------------------------------------
interface dfst_in_if;
  logic                                valid;
  logic                                ready;
  logic [dfst_pkg::KIND_W-1:0]         kind;
  logic signed [dfst_pkg::VALUE_W-1:0] elem_value;

  modport source (output valid, output kind, output elem_value, input ready);
  modport sink   (input valid, input kind, input elem_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/dfst_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfst_out_if: result channel
// Valid/ready channel that carries the status of one finished operation.
// ----------------------------------------------------------------------------
interface dfst_out_if;
  logic                         valid;
  logic                         ready;
  logic                         success;
  logic                         full_reject;
  logic [dfst_pkg::COUNT_W-1:0] count;
  logic                         is_empty;

  modport source (output valid, output success, output full_reject,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input success, input full_reject,
                  input count, input is_empty, output ready);
endinterface
`default_nettype wire

// ===== rtl/dfst_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfst_mem: entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dfst_mem (
  input  wire logic              clk_i,
  input  wire dfst_pkg::mem_req_t req_i,
  output dfst_pkg::elem_t        rdata_o
);
  import dfst_pkg::*;

  elem_t mem_q [CAPACITY];
  elem_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/dfst_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfst_ctrl: sequencer and compare unit
// Scans the stored entries through one read port and one comparator,
// appends on add, and compacts the entries after a removal.
// ----------------------------------------------------------------------------
module dfst_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  dfst_in_if.sink                 in_i,
  output dfst_pkg::mem_req_t      mem_req_o,
  input  wire dfst_pkg::elem_t    rdata_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output dfst_pkg::result_t       res_o
);
  import dfst_pkg::*;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  elem_t  val_q, val_d;
  cnt_t   cnt_q, cnt_d;
  cnt_t   rd_idx_q, rd_idx_d;
  logic   cmp_vld_q, cmp_vld_d;
  idx_t   cmp_idx_q, cmp_idx_d;
  logic   found_q, found_d;
  idx_t   pos_q, pos_d;
  logic   ok_q, ok_d;
  logic   rej_q, rej_d;

  logic   in_fire;
  logic   issue_en;
  logic   match;
  logic   drained;

  assign in_fire  = in_i.valid && in_i.ready;
  assign issue_en = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (rd_idx_q < cnt_q);
  assign match    = cmp_vld_q && (rdata_i == val_q);
  // nothing more to read and nothing left in flight
  assign drained  = !issue_en && !cmp_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (kind_e'(in_i.kind) == KIND_NONE) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || drained) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = (kind_q == KIND_REMOVE && found_q) ? ST_SHIFT : ST_DONE;
      end
      ST_SHIFT: begin
        if (drained) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_d    = kind_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    found_d   = found_q;
    pos_d     = pos_q;
    ok_d      = ok_q;
    rej_d     = rej_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = cnt_q[IDX_W-1:0];
    mem_req_o.wdata = val_q;
    mem_req_o.raddr = rd_idx_q[IDX_W-1:0];

    in_i.ready  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d   = kind_e'(in_i.kind);
          val_d    = to_elem(in_i.elem_value);
          rd_idx_d = '0;
          found_d  = 1'b0;
          ok_d     = 1'b0;
          rej_d    = 1'b0;
        end
      end
      ST_SCAN: begin
        cmp_vld_d = issue_en;
        cmp_idx_d = rd_idx_q[IDX_W-1:0];
        if (issue_en) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (match) begin
          found_d = 1'b1;
          pos_d   = cmp_idx_q;
        end
      end
      ST_DECIDE: begin
        case (kind_q)
          KIND_ADD: begin
            if (!found_q) begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                rej_d = 1'b1;
              end else begin
                mem_req_o.we = 1'b1;
                cnt_d        = cnt_q + 1'b1;
                ok_d         = 1'b1;
              end
            end
          end
          KIND_REMOVE: begin
            // compaction starts with the entry right after the match
            rd_idx_d = CNT_W'(pos_q) + 1'b1;
          end
          KIND_SEARCH: ok_d = found_q;
          default: ;
        endcase
      end
      ST_SHIFT: begin
        cmp_vld_d = issue_en;
        cmp_idx_d = rd_idx_q[IDX_W-1:0];
        if (issue_en) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (cmp_vld_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cmp_idx_q - 1'b1;
          mem_req_o.wdata = rdata_i;
        end
        if (drained) begin
          cnt_d = cnt_q - 1'b1;
          ok_d  = 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase

    res_o.success     = ok_q;
    res_o.full_reject = rej_q;
    res_o.count       = COUNT_W'(cnt_q);
    res_o.is_empty    = (cnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    val_q     <= val_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    ok_q      <= ok_d;
    rej_q     <= rej_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == ST_DECIDE || state_q == ST_SHIFT))
    else $error("entry write outside decide or shift");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && rej_q) |-> (cnt_q == CNT_W'(CAPACITY) && !ok_q))
    else $error("reject while not full or with success");

  a_shift_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && !drained) |=> $stable(cnt_q))
    else $error("count moved during compaction");

endmodule
`default_nettype wire

// ===== rtl/duplicate_free_set_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// duplicate_free_set_table: set of distinct values in an ordered array
// Add appends absent values, remove deletes the first match and closes the
// gap, search reports presence; every operation returns one status beat.
// ----------------------------------------------------------------------------
//  channel  dir  beat carries
//  in_i     in   kind, elem_value
//  out_o    out  success, full_reject, count, is_empty
//
//  An operation scans the stored entries through one read port and one
//  comparator: accept, scan, decide and done; the scan stops at a match.
//  A remove that hits then compacts the entries behind the match before
//  done. An unused kind skips scan and decide and goes straight to done.
//  The result is registered before it shows on out_o.
//  One operation is in flight at a time; in_i.ready is high only when idle.
//  Reset clears the count; the entry memory needs no clearing pass.
//  A stalled out_o holds the result register and the next operation waits
//  in its final cycle until the register is free.
// ----------------------------------------------------------------------------
module duplicate_free_set_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dfst_in_if.sink   in_i,
  dfst_out_if.source out_o
);
  import dfst_pkg::*;

  mem_req_t mem_req;
  elem_t    rdata;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  result_t  out_q;
  logic     out_vld_q;

  dfst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  dfst_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign res_ready = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.success     = out_q.success;
  assign out_o.full_reject = out_q.full_reject;
  assign out_o.count       = out_q.count;
  assign out_o.is_empty    = out_q.is_empty;

endmodule
`default_nettype wire
